[rtl/fsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg - shared types and constants for the flywheel speed controller
// Field widths, fixed-point scales, register indexes and the divider
// request/response structs used by the top level and the serial divider.
// ----------------------------------------------------------------------------
package fsc_pkg;

    // Field widths
    localparam int TARGET_W    = 14;
    localparam int COUNT_W     = 32;
    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 14;
    localparam int DRIVE_W     = 17;
    localparam int GAIN_W      = 24;
    localparam int STEP_W      = 20;
    localparam int ERR_W       = 16;
    localparam int RATE_W      = 17;

    // Stream packing
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Estimator constants
    localparam int COUNTS_DIVISOR = 6;
    localparam int FILTER_SHIFT   = 4;

    // Count delta times the microsecond scale fits in 40 bits
    localparam int DVD_W = 40;
    // Time delta times the counts divisor
    localparam int DVS_W = TIME_W + $clog2(COUNTS_DIVISOR);

    // Shared multiplier: unsigned gain by signed operand
    localparam int MB_W   = 21;
    localparam int PROD_W = GAIN_W + 1 + MB_W;
    // Accumulator for the PD sum and the speed filter
    localparam int ACC_W  = 43;

    localparam int DRIVE_FRAC = 16;
    localparam int HALF_LSB   = 1 << (DRIVE_FRAC - 1);

    localparam logic [GAIN_W-1:0]  RATE_SCALE = 24'd1000000;
    localparam logic [DRIVE_W-1:0] FULL_DRIVE = 17'd65536;

    // Register reset values
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 24'd25770;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 24'd429497;
    localparam logic [TIME_W-1:0]   INTERVAL_RST   = 32'd100000;
    localparam logic [TARGET_W-1:0] LOW_RPM_RST    = 14'd1300;
    localparam logic [DRIVE_W-1:0]  LOW_DRIVE_RST  = 17'd9830;
    localparam logic [SPEED_W-1:0]  MAX_RPM_RST    = 14'd10000;
    localparam logic [STEP_W-1:0]   MAX_STEP_RST   = 20'd10000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_DERIV_GAIN     = 3'd1,
        REG_UPDATE_INTERVAL = 3'd2,
        REG_LOW_TARGET_RPM = 3'd3,
        REG_LOW_TARGET_DRIVE = 3'd4,
        REG_MAX_RPM        = 3'd5,
        REG_MAX_COUNT_STEP = 3'd6
    } cfg_reg_e;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/flywheel_speed_pd_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flywheel_speed_pd_controller - encoder rate estimate with incremental PD drive
// Processing: an input beat with no update due goes from S_CHECK straight to
//   S_OUT; a full update also waits on the 40-step serial divider.
// Throughput: one item at a time; s_tready is high only while idle. A result
//   may wait in the output register while the next item is taken.
// Reset (rst_n low, asynchronous): registers to defaults, state cleared, idle.
// ----------------------------------------------------------------------------
module flywheel_speed_pd_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    // target_rpm[13:0], encoder_count[45:14], time_us[77:46], zero pad
    input  logic [fsc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // motor_drive[16:0], speed_estimate[30:17], zero pad
    output logic [fsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // control_ran[0], reading_rejected[1]
    output logic [fsc_pkg::OUT_TUSER_W-1:0]    m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fsc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_JUMP, S_DT, S_MDC, S_DIVGO, S_DIVWAIT, S_EST1,
        S_EST2, S_SPEED, S_ERR, S_MP, S_MD, S_SUM, S_FIN, S_CLAMP, S_OUT
    } state_t;

    // Configuration registers
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [TIME_W-1:0]   interval_reg;
    logic [TARGET_W-1:0] low_rpm_reg;
    logic [DRIVE_W-1:0]  low_drive_reg;
    logic [SPEED_W-1:0]  max_rpm_reg;
    logic [STEP_W-1:0]   max_step_reg;

    // Controller state
    logic [COUNT_W-1:0]       last_count_reg;
    logic [TIME_W-1:0]        last_count_time_reg;
    logic [SPEED_W-1:0]       last_speed_reg;
    logic signed [ERR_W-1:0]  last_error_reg;
    logic [DRIVE_W-1:0]       drive_level_reg;
    logic [TIME_W-1:0]        last_update_time_reg;

    // Working registers
    state_t                   state_reg;
    logic [TARGET_W-1:0]      target_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [COUNT_W:0]  dc_reg;
    logic [TIME_W-1:0]        dt_reg;
    logic [DVS_W-1:0]         divisor_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     ran_reg;
    logic                     rej_reg;

    // Output register
    logic                     out_valid_reg;
    logic [DRIVE_W-1:0]       out_drive_reg;
    logic [SPEED_W-1:0]       out_speed_reg;
    logic                     out_ran_reg;
    logic                     out_rej_reg;

    // Datapath nets
    logic [GAIN_W-1:0]            mul_a;
    logic signed [MB_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]     prod_next;
    logic [TIME_W-1:0]            elapsed;
    logic signed [COUNT_W:0]      dc_next;
    logic [SPEED_W+FILTER_SHIFT-1:0] ls_scaled;
    logic [ACC_W-FILTER_SHIFT-1:0]   est;
    logic [ERR_W-2:0]             abs_err;
    logic [ERR_W+2:0]             abs_err_x10;
    logic                         outside_band;
    logic [DRIVE_W-1:0]           low_drive_sat;
    logic [ACC_W-DRIVE_FRAC-2:0]  drive_q;
    div_req_t                     div_req;
    div_rsp_t                     div_rsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            interval_reg   <= INTERVAL_RST;
            low_rpm_reg    <= LOW_RPM_RST;
            low_drive_reg  <= LOW_DRIVE_RST;
            max_rpm_reg    <= MAX_RPM_RST;
            max_step_reg   <= MAX_STEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_PROP_GAIN:        prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:       deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_UPDATE_INTERVAL:  interval_reg   <= cfg_data[TIME_W-1:0];
                REG_LOW_TARGET_RPM:   low_rpm_reg    <= cfg_data[TARGET_W-1:0];
                REG_LOW_TARGET_DRIVE: low_drive_reg  <= cfg_data[DRIVE_W-1:0];
                REG_MAX_RPM:          max_rpm_reg    <= cfg_data[SPEED_W-1:0];
                REG_MAX_COUNT_STEP:   max_step_reg   <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_MDC:
            begin
                mul_a = RATE_SCALE;
                mul_b = MB_W'({1'b0, dc_reg[STEP_W-1:0]});
            end
            S_MD:
            begin
                mul_a = deriv_gain_reg;
                mul_b = MB_W'(rate_reg);
            end
            default:
            begin
                mul_a = prop_gain_reg;
                mul_b = MB_W'(err_reg);
            end
        endcase
        prod_next = $signed({1'b0, mul_a}) * mul_b;
    end

    // Side computations for the sequencer
    always_comb
    begin
        elapsed      = now_reg - last_update_time_reg;
        dc_next      = $signed({count_reg[COUNT_W-1], count_reg})
                     - $signed({last_count_reg[COUNT_W-1], last_count_reg});
        ls_scaled    = {last_speed_reg, {FILTER_SHIFT{1'b0}}}
                     - (SPEED_W+FILTER_SHIFT)'(last_speed_reg);
        est          = acc_reg[ACC_W-1:FILTER_SHIFT];
        abs_err      = err_reg[ERR_W-1] ? (ERR_W-1)'(-err_reg) : (ERR_W-1)'(err_reg);
        abs_err_x10  = (ERR_W+3)'({abs_err, 3'b000}) + (ERR_W+3)'({abs_err, 1'b0});
        outside_band = (abs_err_x10 > (ERR_W+3)'(target_reg));
        low_drive_sat = (low_drive_reg > FULL_DRIVE) ? FULL_DRIVE : low_drive_reg;
        drive_q      = acc_reg[ACC_W-2:DRIVE_FRAC];
    end

    assign div_req.start    = (state_reg == S_DIVGO);
    assign div_req.dividend = prod_reg[DVD_W-1:0];
    assign div_req.divisor  = divisor_reg;

    fsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer, controller state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            last_count_reg       <= '0;
            last_count_time_reg  <= '0;
            last_speed_reg       <= '0;
            last_error_reg       <= '0;
            drive_level_reg      <= '0;
            last_update_time_reg <= '0;
            target_reg           <= '0;
            count_reg            <= '0;
            now_reg              <= '0;
            dc_reg               <= '0;
            dt_reg               <= '0;
            divisor_reg          <= '0;
            err_reg              <= '0;
            rate_reg             <= '0;
            acc_reg              <= '0;
            prod_reg             <= '0;
            ran_reg              <= 1'b0;
            rej_reg              <= 1'b0;
            out_valid_reg        <= 1'b0;
            out_drive_reg        <= '0;
            out_speed_reg        <= '0;
            out_ran_reg          <= 1'b0;
            out_rej_reg          <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_next;

            // Drop the result beat once taken, unless a new one loads now
            if (m_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        target_reg <= s_tdata[TARGET_W-1:0];
                        count_reg  <= s_tdata[TARGET_W +: COUNT_W];
                        now_reg    <= s_tdata[TARGET_W+COUNT_W +: TIME_W];
                        ran_reg    <= 1'b0;
                        rej_reg    <= 1'b0;
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (elapsed > interval_reg)
                    begin
                        last_update_time_reg <= now_reg;
                        dc_reg               <= dc_next;
                        state_reg            <= S_JUMP;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_JUMP:
                begin
                    // Backward or huge jump: resync and keep the speed
                    if (dc_reg[COUNT_W] || (dc_reg[COUNT_W-1:0] > COUNT_W'(max_step_reg)))
                    begin
                        rej_reg             <= 1'b1;
                        last_count_reg      <= count_reg;
                        last_count_time_reg <= now_reg;
                        state_reg           <= S_SPEED;
                    end
                    else
                    begin
                        dt_reg    <= now_reg - last_count_time_reg;
                        state_reg <= S_DT;
                    end
                end
                S_DT:
                begin
                    if (dt_reg == '0)
                    begin
                        rej_reg   <= 1'b1;
                        state_reg <= S_SPEED;
                    end
                    else
                    begin
                        divisor_reg <= DVS_W'(dt_reg) * DVS_W'(COUNTS_DIVISOR);
                        state_reg   <= S_MDC;
                    end
                end
                S_MDC:
                begin
                    state_reg <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg   <= $signed(ACC_W'(div_rsp.quotient));
                        state_reg <= S_EST1;
                    end
                end
                S_EST1:
                begin
                    // Filter: add (2^shift - 1) times the old speed
                    acc_reg   <= acc_reg + $signed(ACC_W'(ls_scaled));
                    state_reg <= S_EST2;
                end
                S_EST2:
                begin
                    if ((est == '0) || (est > (ACC_W-FILTER_SHIFT)'(max_rpm_reg)))
                    begin
                        rej_reg <= 1'b1;
                    end
                    else
                    begin
                        last_count_reg      <= count_reg;
                        last_count_time_reg <= now_reg;
                        last_speed_reg      <= est[SPEED_W-1:0];
                    end
                    state_reg <= S_SPEED;
                end
                S_SPEED:
                begin
                    // Skip the drive update on a stale speed above the limit
                    if (last_speed_reg > max_rpm_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ran_reg   <= 1'b1;
                        err_reg   <= $signed(ERR_W'(last_speed_reg)) - $signed(ERR_W'(target_reg));
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    rate_reg <= RATE_W'(err_reg) - RATE_W'(last_error_reg);
                    priority if ((target_reg != '0) && (target_reg < low_rpm_reg))
                    begin
                        drive_level_reg <= low_drive_sat;
                        last_error_reg  <= err_reg;
                        state_reg       <= S_OUT;
                    end
                    else if (target_reg == '0)
                    begin
                        drive_level_reg <= '0;
                        last_error_reg  <= err_reg;
                        state_reg       <= S_OUT;
                    end
                    else if (outside_band)
                    begin
                        state_reg <= S_MP;
                    end
                    else
                    begin
                        last_error_reg <= err_reg;
                        state_reg      <= S_OUT;
                    end
                end
                S_MP:
                begin
                    state_reg <= S_MD;
                end
                S_MD:
                begin
                    acc_reg   <= prod_reg[ACC_W-1:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    acc_reg   <= acc_reg + prod_reg[ACC_W-1:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // Old drive in Q16, minus the PD step, plus half for rounding
                    acc_reg   <= ($signed(ACC_W'(drive_level_reg)) <<< DRIVE_FRAC)
                               - acc_reg + $signed(ACC_W'(HALF_LSB));
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    priority if (acc_reg[ACC_W-1])
                    begin
                        drive_level_reg <= '0;
                    end
                    else if (drive_q > (ACC_W-DRIVE_FRAC-1)'(FULL_DRIVE))
                    begin
                        drive_level_reg <= FULL_DRIVE;
                    end
                    else
                    begin
                        drive_level_reg <= drive_q[DRIVE_W-1:0];
                    end
                    last_error_reg <= err_reg;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    // Load the result once the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_drive_reg <= drive_level_reg;
                        out_speed_reg <= last_speed_reg;
                        out_ran_reg   <= ran_reg;
                        out_rej_reg   <= rej_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-DRIVE_W-SPEED_W)'(0), out_speed_reg, out_drive_reg};
    assign m_tuser  = {out_rej_reg, out_ran_reg};

endmodule

[rtl/fsc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_div - serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient is final.
// ----------------------------------------------------------------------------
module fsc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  fsc_pkg::div_req_t req,
    output fsc_pkg::div_rsp_t rsp
);
    import fsc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;
    logic             fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quot_reg[DVD_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    // Iterate one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quot_reg    <= req.dividend;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
                cnt_reg     <= CNT_W'(DVD_W);
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
                quot_reg <= {quot_reg[DVD_W-2:0], fits};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

[rtl/fsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_checker - port-level checks for the flywheel speed controller
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fsc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [fsc_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import fsc_pkg::*;

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    // Drive never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DRIVE_W-1:0] <= FULL_DRIVE))
        else $error("motor drive above full scale");

    // Input side closes after each accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready held after accept");

    // A new result appears only at the end of processing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while input side idle");

endmodule

bind flywheel_speed_pd_controller fsc_checker u_fsc_checker (.*);

[tb/tb_flywheel_speed_pd_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flywheel_speed_pd_controller - self-checking bench for the speed loop
// Drives target/encoder/timestamp beats through the input stream and checks
// every drive/speed result against a cycle-free model of the estimator and
// incremental PD step. A directed table covers the reject paths, deadband
// edges, drive clamps and timestamp wrap; random traffic then runs under
// several register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_flywheel_speed_pd_controller;
    import fsc_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 64;
    localparam int N_DIRECTED    = 19;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [SPEED_W-1:0] speed;
        logic               ran;
        logic               rejected;
    } loop_result_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   now;
        logic                typed;
        loop_result_t        want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_PROP_GAIN;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Register copies
    logic [GAIN_W-1:0]   gain_p      = PROP_GAIN_RST;
    logic [GAIN_W-1:0]   gain_d      = DERIV_GAIN_RST;
    logic [TIME_W-1:0]   interval_us = INTERVAL_RST;
    logic [TARGET_W-1:0] low_rpm     = LOW_RPM_RST;
    logic [DRIVE_W-1:0]  low_drive   = LOW_DRIVE_RST;
    logic [SPEED_W-1:0]  max_rpm_lim = MAX_RPM_RST;
    logic [STEP_W-1:0]   max_step    = MAX_STEP_RST;

    // Controller state copies
    longint              prev_count       = 0;
    logic [TIME_W-1:0]   prev_count_time  = '0;
    logic [SPEED_W-1:0]  speed_q          = '0;
    longint              prev_err         = 0;
    logic [DRIVE_W-1:0]  drive_q          = '0;
    logic [TIME_W-1:0]   prev_update_time = '0;

    loop_result_t pending_results[$];

    // Random traffic shaping
    bit                steady = 1'b0;
    int                wheel_rpm = 3000;
    logic [TIME_W-1:0] gen_time = '0;
    logic [COUNT_W-1:0] gen_count = '0;

    int items_sent = 0;
    int results_seen = 0;
    int n_updates = 0;
    int n_rejected = 0;
    int n_stale = 0;
    int n_settings = 1;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Wheel spin-up, reject paths, deadband edges, clamps and timestamp wrap
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{14'd0,     32'd0,          32'd0,          1'b1, '{17'd0, 14'd0, 1'b0, 1'b0}},
        '{14'd0,     32'd0,          32'd100001,     1'b1, '{17'd0, 14'd0, 1'b1, 1'b1}},
        '{14'd0,     32'd5,          32'd0,          1'b1, '{17'd0, 14'd0, 1'b1, 1'b1}},
        '{14'd0,     32'hFFFF_FFFB,  32'd200000,     1'b1, '{17'd0, 14'd0, 1'b1, 1'b1}},
        '{14'd16383, 32'd20000,      32'd300001,     1'b1, '{17'd65536, 14'd0, 1'b1, 1'b1}},
        '{14'd0,     32'd29600,      32'd400002,     1'b0, '0},
        '{14'd500,   32'd38000,      32'd500003,     1'b0, '0},
        '{14'd16383, 32'd46000,      32'd600004,     1'b0, '0},
        '{14'd1300,  32'd54000,      32'd700005,     1'b0, '0},
        '{14'd1299,  32'd62000,      32'd800006,     1'b0, '0},
        '{14'd4500,  32'd70000,      32'd900007,     1'b0, '0},
        '{14'd5541,  32'd78000,      32'd1000008,    1'b0, '0},
        '{14'd6121,  32'd86000,      32'd1100009,    1'b0, '0},
        '{14'd8000,  32'h7FFF_FFFF,  32'd1200010,    1'b0, '0},
        '{14'd3000,  32'h8000_0000,  32'd1300011,    1'b0, '0},
        '{14'd12000, 32'h8000_0064,  32'hFFFF_FFFF,  1'b0, '0},
        '{14'd12000, 32'h8000_00C8,  32'd99999,      1'b0, '0},
        '{14'd12000, 32'h8000_0450,  32'd100000,     1'b0, '0},
        '{14'd0,     32'h8000_0500,  32'd200001,     1'b0, '0}
    };

    flywheel_speed_pd_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the speed loop by one item and return the drive/speed it reports
    function automatic loop_result_t step_controller(input logic [TARGET_W-1:0] target,
                                                     input logic [COUNT_W-1:0] count_bits,
                                                     input logic [TIME_W-1:0] now);
        loop_result_t      res;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] dt;
        longint            count;
        longint            dc;
        longint            raw;
        longint            est;
        longint            err;
        longint            rate;
        longint            band;
        longint            delta;
        longint            v;
        res = '0;
        elapsed = now - prev_update_time;
        if (elapsed > interval_us)
        begin
            prev_update_time = now;
            n_updates++;
            count = longint'($signed(count_bits));
            dc = count - prev_count;
            dt = now - prev_count_time;
            // Backward or oversized jump: resync the count reference
            if (count < prev_count || dc > longint'(max_step))
            begin
                prev_count = count;
                prev_count_time = now;
                res.rejected = 1'b1;
            end
            else if (dt == 0)
            begin
                res.rejected = 1'b1;
            end
            else
            begin
                raw = (dc * 1000000) / longint'(dt);
                raw = raw / COUNTS_DIVISOR;
                est = (longint'(speed_q) * ((1 << FILTER_SHIFT) - 1) + raw) /
                      (1 << FILTER_SHIFT);
                if (est <= 0 || est > longint'(max_rpm_lim))
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    prev_count = count;
                    prev_count_time = now;
                    speed_q = est[SPEED_W-1:0];
                end
            end
            if (res.rejected)
                n_rejected++;

            // Skip the drive step while the held speed is above the limit
            if (speed_q <= max_rpm_lim)
            begin
                err = longint'(speed_q) - longint'(target);
                rate = err - prev_err;
                band = longint'(target) / 10;
                if (target != 0 && target < low_rpm)
                begin
                    drive_q = (low_drive > FULL_DRIVE) ? FULL_DRIVE : low_drive;
                end
                else if (target == 0)
                begin
                    drive_q = '0;
                end
                else if (err > band || -err > band)
                begin
                    delta = longint'(gain_p) * err + longint'(gain_d) * rate;
                    v = longint'(drive_q) * 65536 - delta + 32768;
                    if (v < 0)
                        drive_q = '0;
                    else
                    begin
                        v = v / 65536;
                        drive_q = (v > longint'(FULL_DRIVE)) ? FULL_DRIVE : v[DRIVE_W-1:0];
                    end
                end
                prev_err = err;
                res.ran = 1'b1;
            end
            else
            begin
                n_stale++;
            end
        end
        res.drive = drive_q;
        res.speed = speed_q;
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    task automatic send_item(input logic [TARGET_W-1:0] tgt, input logic [COUNT_W-1:0] cnt,
                             input logic [TIME_W-1:0] now, input logic typed,
                             input loop_result_t want);
        int           gap;
        loop_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= IN_TDATA_W'({now, cnt, tgt});
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = step_controller(tgt, cnt, now);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Hold the input stream until every expected result has drained
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PROP_GAIN:        gain_p = val[GAIN_W-1:0];
            REG_DERIV_GAIN:       gain_d = val[GAIN_W-1:0];
            REG_UPDATE_INTERVAL:  interval_us = val[TIME_W-1:0];
            REG_LOW_TARGET_RPM:   low_rpm = val[TARGET_W-1:0];
            REG_LOW_TARGET_DRIVE: low_drive = val[DRIVE_W-1:0];
            REG_MAX_RPM:          max_rpm_lim = val[SPEED_W-1:0];
            REG_MAX_COUNT_STEP:   max_step = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Load a full register set; the block must be idle
    task automatic program_regs(input logic [31:0] p, input logic [31:0] d,
                                input logic [31:0] iv, input logic [31:0] lr,
                                input logic [31:0] ld, input logic [31:0] mr,
                                input logic [31:0] ms);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_UPDATE_INTERVAL, iv);
        write_reg(REG_LOW_TARGET_RPM, lr);
        write_reg(REG_LOW_TARGET_DRIVE, ld);
        write_reg(REG_MAX_RPM, mr);
        write_reg(REG_MAX_COUNT_STEP, ms);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly a plausible spinning wheel, plus noise and broken sequences
    task automatic run_random(input int n_items);
        logic [TARGET_W-1:0] tgt;
        logic [COUNT_W-1:0]  cnt;
        logic [TIME_W-1:0]   now;
        longint              step;
        longint              dc;
        longint              span;
        int                  t;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    wheel_rpm = $urandom_range(0, 16383);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                tgt = $urandom_range(0, 16383);
                cnt = $urandom;
                now = $urandom_range(0, 1) ? $urandom : gen_time + $urandom_range(0, 50);
            end
            else
            begin
                span = (interval_us == 0) ? 3000 :
                       (interval_us > 150000) ? 150000 : longint'(interval_us);
                step = longint'(interval_us) + 1 + longint'($urandom_range(0, span));
                now = gen_time + step[TIME_W-1:0];
                dc = longint'(wheel_rpm) * COUNTS_DIVISOR * step / 1000000 +
                     longint'($urandom_range(0, 4)) - 2;
                cnt = gen_count + dc[COUNT_W-1:0];
                case ($urandom_range(0, 9))
                    0: tgt = '0;
                    1: tgt = $urandom_range(0, low_rpm);
                    2, 3: tgt = $urandom_range(0, 16383);
                    default:
                    begin
                        t = wheel_rpm + int'($urandom_range(0, 1000)) - 500;
                        if (t < 0)
                            t = 0;
                        if (t > 16383)
                            t = 16383;
                        tgt = t[TARGET_W-1:0];
                    end
                endcase
            end
            gen_time = now;
            gen_count = cnt;
            send_item(tgt, cnt, now, 1'b0, '0);
            if ($urandom_range(0, 149) == 0)
                wait_drained();
        end
    endtask

    // Receiver: random stalls, none during steady stretches
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        loop_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: tdata=%h tuser=%b", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("motor_drive", want.drive, m_tdata[DRIVE_W-1:0]);
                compare_field("speed_estimate", want.speed, m_tdata[DRIVE_W +: SPEED_W]);
                compare_field("control_ran", want.ran, m_tuser[0]);
                compare_field("reading_rejected", want.rejected, m_tuser[1]);
            end
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under reset register values
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].target, directed_rows[i].count, directed_rows[i].now,
                      directed_rows[i].typed, directed_rows[i].want);
        gen_time = directed_rows[N_DIRECTED-1].now;
        gen_count = directed_rows[N_DIRECTED-1].count;
        run_random(250);

        // Maximum gains, update on every new timestamp, widest limits
        wait_drained();
        program_regs(32'hFF_FFFF, 32'hFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd16383, 32'hF_FFFF);
        run_random(220);

        // Tightest limits: held speed goes stale, drive updates are skipped
        wait_drained();
        program_regs(32'd0, 32'd0, 32'd1000, 32'd16383, 32'd65536, 32'd1, 32'd1);
        run_random(80);

        // Mid gains, oversized low-target drive that must saturate
        wait_drained();
        program_regs($urandom_range(0, 200000), $urandom_range(0, 2000000), 32'd50000,
                     32'd3000, 32'h1_FFFF, 32'd16383, 32'd50000);
        run_random(250);

        // Longest interval: no update can ever fire
        wait_drained();
        program_regs(32'd25770, 32'd429497, 32'hFFFF_FFFF, 32'd1300, 32'd9830,
                     32'd16383, 32'd10000);
        run_random(30);

        // Random gains with a moderate interval
        wait_drained();
        program_regs($urandom_range(0, 100000), $urandom_range(0, 1000000), 32'd20000,
                     32'd1300, 32'd9830, 32'd16383, 32'd10000);
        run_random(220);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d input beats and %0d result beats over %0d register sets.",
                 items_sent, results_seen, n_settings);
        $display("Control updates: %0d, rejected readings: %0d, skipped on stale speed: %0d.",
                 n_updates, n_rejected, n_stale);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
